>>> sv/tlptm_pkg.sv
// tlptm_pkg: shared widths, entry masks, request and status codes and the
// sequencer state type of the two-level page table manager
// no dependencies
package tlptm_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned FLAGS_W      = 12;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned DIR_ENTRIES  = 1024;
  localparam int unsigned TBL_ENTRIES  = 1024;
  localparam int unsigned NUM_TABLES_DEF = 16;

  localparam logic [ADDR_W-1:0] LARGE_MASK = 32'hFFC0_0000;
  localparam logic [ADDR_W-1:0] SMALL_MASK = 32'hFFFF_F000;
  localparam logic [ADDR_W-1:0] LARGE_BIT  = 32'h0000_0080;
  localparam logic [ADDR_W-1:0] PRESENT_BIT = 32'h0000_0001;

  localparam int unsigned PRESENT_POS = 0;
  localparam int unsigned LARGE_POS   = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_MAP_LARGE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MAP_SMALL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TRANSLATE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_TABLE,
    S_RESULT
  } seq_state_e;

endpackage

>>> sv/tlptm_if.sv
// tlptm_req_if, tlptm_rsp_if: valid/ready channels for request and result words
// depends on tlptm_pkg
interface tlptm_req_if;
  logic                           valid;
  logic                           ready;
  logic [tlptm_pkg::REQ_W-1:0]    req_type;
  logic [tlptm_pkg::ADDR_W-1:0]   phys_addr;
  logic [tlptm_pkg::ADDR_W-1:0]   lin_addr;
  logic [tlptm_pkg::FLAGS_W-1:0]  entry_flags;

  modport source (output valid, req_type, phys_addr, lin_addr, entry_flags, input ready);
  modport sink   (input valid, req_type, phys_addr, lin_addr, entry_flags, output ready);
endinterface

interface tlptm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [tlptm_pkg::ADDR_W-1:0]    frame_base;
  logic [tlptm_pkg::STATUS_W-1:0]  status;

  modport source (output valid, frame_base, status, input ready);
  modport sink   (input valid, frame_base, status, output ready);
endinterface

>>> sv/two_level_page_table_manager.sv
// two_level_page_table_manager: page directory, pool of second-level tables
// and a small sequencer that maps 4 MB / 4 KB pages and translates addresses
// depends on tlptm_pkg and the channel interfaces in tlptm_if.sv

// After reset the block runs a clearing pass over its two memories, one
// entry per cycle, over all NUM_TABLES*1024 table rows (16384 at the
// default); no request word is taken until it ends. Then each request word
// occupies the block on its own: maps, unknown codes and translates that
// stop at the directory pass S_DECIDE and S_RESULT, and a translate that
// walks into a second-level table passes S_DECIDE, S_TABLE and S_RESULT.
// The directory and table memories are read one after the other with
// registered read data. A result word sits in an output register, so the
// next request is taken while it waits. Tables are handed out in ascending
// order and never returned, so the lowest free table is simply the
// allocation count.
module two_level_page_table_manager #(
  parameter int unsigned NUM_TABLES = tlptm_pkg::NUM_TABLES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlptm_req_if.sink   req_i,
  tlptm_rsp_if.source rsp_o
);
  import tlptm_pkg::*;

  localparam int unsigned TW        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned NFW       = $clog2(NUM_TABLES + 1);
  localparam int unsigned TA_W      = TW + IDX_W;
  localparam int unsigned TBL_DEPTH = NUM_TABLES * TBL_ENTRIES;
  localparam logic [TA_W-1:0]  CLR_LAST = TA_W'(TBL_DEPTH - 1);
  localparam logic [NFW-1:0]   NT_NF    = NFW'(NUM_TABLES);
  localparam logic [IDX_W:0]   NT_IDX   = (IDX_W + 1)'(NUM_TABLES);

  // memories
  logic [ADDR_W-1:0] dir_mem [DIR_ENTRIES];
  logic [ADDR_W-1:0] tbl_mem [TBL_DEPTH];

  seq_state_e state_q, state_d;

  // captured request
  logic [REQ_W-1:0]   req_q;
  logic [ADDR_W-1:0]  phys_q;
  logic [ADDR_W-1:0]  lin_q;
  logic [FLAGS_W-1:0] flags_q;

  logic [TA_W-1:0]    clr_q;
  logic [NFW-1:0]     next_free_q;
  logic               alloc;

  logic [ADDR_W-1:0]  dir_rdata_q, tbl_rdata_q;

  // memory port controls
  logic               dir_we, dir_re, tbl_we, tbl_re;
  logic [IDX_W-1:0]   dir_waddr, dir_raddr;
  logic [ADDR_W-1:0]  dir_wdata, tbl_wdata;
  logic [TA_W-1:0]    tbl_waddr, tbl_raddr;

  // pending result and output register
  logic [ADDR_W-1:0]   res_frame_q, res_frame_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_frame_q;
  logic [STATUS_W-1:0] out_status_q;

  logic accept, out_free, out_load;

  // directory entry decode, shared by both map-small and translate
  logic [IDX_W-1:0] ent_tbl;
  logic             ent_present, ent_large, ent_holds, ent_tbl_ok, pool_ok;
  logic [TW-1:0]    tsel;
  logic [IDX_W-1:0] dir_idx, tbl_idx;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign out_load = (state_q == S_RESULT) && out_free;

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.frame_base = out_frame_q;
  assign rsp_o.status   = out_status_q;

  assign dir_idx     = lin_q[ADDR_W-1 -: IDX_W];
  assign tbl_idx     = lin_q[ADDR_W-IDX_W-1 -: IDX_W];
  assign ent_tbl     = dir_rdata_q[ADDR_W-IDX_W-1 -: IDX_W];
  assign ent_present = dir_rdata_q[PRESENT_POS];
  assign ent_large   = dir_rdata_q[LARGE_POS];
  assign ent_holds   = ent_present && !ent_large;
  assign ent_tbl_ok  = {1'b0, ent_tbl} < NT_IDX;
  assign pool_ok     = next_free_q < NT_NF;
  // reuse the table the entry already holds, else the lowest free one
  assign tsel = (ent_holds && ent_tbl_ok) ? ent_tbl[TW-1:0] : next_free_q[TW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_q == CLR_LAST) state_d = S_IDLE;
      S_IDLE:   if (accept) state_d = S_DECIDE;
      S_DECIDE: begin
        if (req_q == REQ_TRANSLATE && ent_holds && ent_tbl_ok) state_d = S_TABLE;
        else state_d = S_RESULT;
      end
      S_TABLE:  state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  // datapath controls
  always_comb begin
    dir_we       = 1'b0;
    dir_waddr    = dir_idx;
    dir_wdata    = '0;
    dir_re       = 1'b0;
    dir_raddr    = req_i.lin_addr[ADDR_W-1 -: IDX_W];
    tbl_we       = 1'b0;
    tbl_waddr    = {tsel, tbl_idx};
    tbl_wdata    = '0;
    tbl_re       = 1'b0;
    tbl_raddr    = {ent_tbl[TW-1:0], tbl_idx};
    alloc        = 1'b0;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    unique case (state_q)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        dir_we    = (clr_q < TA_W'(DIR_ENTRIES));
        dir_waddr = clr_q[IDX_W-1:0];
      end
      S_IDLE: begin
        dir_re = accept;
      end
      S_DECIDE: begin
        res_frame_d  = '0;
        res_status_d = ST_OK;
        unique case (req_q)
          REQ_MAP_LARGE: begin
            dir_we    = 1'b1;
            dir_wdata = (phys_q & LARGE_MASK) | LARGE_BIT | ADDR_W'(flags_q);
          end
          REQ_MAP_SMALL: begin
            if (ent_holds && ent_tbl_ok) begin
              tbl_we = 1'b1;
            end else if (pool_ok) begin
              alloc     = 1'b1;
              dir_we    = 1'b1;
              dir_wdata = (ADDR_W'(next_free_q) << 12) | PRESENT_BIT;
              tbl_we    = 1'b1;
            end else begin
              res_status_d = ST_NO_TABLE;
            end
            tbl_wdata = (phys_q & SMALL_MASK) | ADDR_W'(flags_q);
          end
          REQ_TRANSLATE: begin
            if (!ent_present) res_status_d = ST_UNMAPPED;
            else if (ent_large) res_frame_d = dir_rdata_q & LARGE_MASK;
            else if (ent_tbl_ok) tbl_re = 1'b1;
            else res_status_d = ST_UNMAPPED;
          end
          default: ;
        endcase
      end
      S_TABLE: begin
        if (!tbl_rdata_q[PRESENT_POS]) res_status_d = ST_UNMAPPED;
        else res_frame_d = tbl_rdata_q & SMALL_MASK;
      end
      S_RESULT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + TA_W'(1);
      if (alloc) next_free_q <= next_free_q + NFW'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_i.req_type;
      phys_q  <= req_i.phys_addr;
      lin_q   <= req_i.lin_addr;
      flags_q <= req_i.entry_flags;
    end
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_frame_q  <= res_frame_q;
      out_status_q <= res_status_q;
    end
  end

  // page directory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (dir_re) dir_rdata_q <= dir_mem[dir_raddr];
  end

  // second-level table pool, table t at rows t*1024 .. t*1024+1023
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  // checks
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= NT_NF)
    else $error("allocation count beyond pool size");

  a_no_table_only_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == ST_NO_TABLE) |-> (next_free_q == NT_NF))
    else $error("empty-pool status with tables still free");

  a_frame_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_frame_q == '0))
    else $error("frame base given with an error status");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECIDE))
    else $error("accepted word not followed by directory decode");

endmodule
